/* src/gcr_pkg.sv */
// Shared types, constants and font ROM for the glyph cell rasterizer.
package gcr_pkg;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 8;
  localparam int COORD_W    = 18;
  localparam int WIN_W      = 12;
  localparam int COLOUR_W   = 16;
  localparam int SCALE_W    = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_QMARK   = 8'd63;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_CELL_SCALE    = 3'd2,
    REG_FORE_COLOUR   = 3'd3,
    REG_BACK_COLOUR   = 3'd4
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  // column 0 is the leftmost byte of a literal
  typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    logic [WIN_W-1:0]    screen_width;
    logic [WIN_W-1:0]    screen_height;
    logic [SCALE_W-1:0]  cell_scale;
    logic [COLOUR_W-1:0] fore_colour;
    logic [COLOUR_W-1:0] back_colour;
  } cfg_t;

  typedef struct packed {
    glyph_t             glyph;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } item_t;

  typedef struct packed {
    logic [WIN_W-1:0]    win_left;
    logic [WIN_W-1:0]    win_top;
    logic [WIN_W-1:0]    win_right;
    logic [WIN_W-1:0]    win_bottom;
    logic [COLOUR_W-1:0] fill_colour;
    logic                visible;
    logic                last;
  } cell_t;

  // fold lower case, map unsupported codes to '?', return ROM row
  function automatic logic [5:0] char_to_index(logic [7:0] code);
    logic [7:0] c;
    logic [7:0] d;
    c = code;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      c = c - CASE_OFFSET;
    end
    if (c < CHAR_SPACE || c > CHAR_UPPER_Z) begin
      c = CHAR_QMARK;
    end
    d = c - CHAR_SPACE;
    return d[5:0];
  endfunction

  function automatic glyph_t font_glyph(logic [5:0] idx);
    glyph_t g;
    unique case (idx)
      6'd0:  g = 40'h0000000000;
      6'd1:  g = 40'h00005F0000;
      6'd2:  g = 40'h0007000700;
      6'd3:  g = 40'h147F147F14;
      6'd4:  g = 40'h242A7F2A12;
      6'd5:  g = 40'h2313086462;
      6'd6:  g = 40'h3649552250;
      6'd7:  g = 40'h0005030000;
      6'd8:  g = 40'h001C224100;
      6'd9:  g = 40'h0041221C00;
      6'd10: g = 40'h14083E0814;
      6'd11: g = 40'h08083E0808;
      6'd12: g = 40'h0050300000;
      6'd13: g = 40'h0808080808;
      6'd14: g = 40'h0060600000;
      6'd15: g = 40'h2010080402;
      6'd16: g = 40'h3E5149453E;
      6'd17: g = 40'h00427F4000;
      6'd18: g = 40'h4261514946;
      6'd19: g = 40'h2141454B31;
      6'd20: g = 40'h1814127F10;
      6'd21: g = 40'h2745454539;
      6'd22: g = 40'h3C4A494930;
      6'd23: g = 40'h0171090503;
      6'd24: g = 40'h3649494936;
      6'd25: g = 40'h064949291E;
      6'd26: g = 40'h0036360000;
      6'd27: g = 40'h0056360000;
      6'd28: g = 40'h0814224100;
      6'd29: g = 40'h1414141414;
      6'd30: g = 40'h0041221408;
      6'd31: g = 40'h0201510906;
      6'd32: g = 40'h324979413E;
      6'd33: g = 40'h7E1111117E;
      6'd34: g = 40'h7F49494936;
      6'd35: g = 40'h3E41414122;
      6'd36: g = 40'h7F4141221C;
      6'd37: g = 40'h7F49494941;
      6'd38: g = 40'h7F09090901;
      6'd39: g = 40'h3E4149497A;
      6'd40: g = 40'h7F0808087F;
      6'd41: g = 40'h00417F4100;
      6'd42: g = 40'h2040413F01;
      6'd43: g = 40'h7F08142241;
      6'd44: g = 40'h7F40404040;
      6'd45: g = 40'h7F020C027F;
      6'd46: g = 40'h7F0408107F;
      6'd47: g = 40'h3E4141413E;
      6'd48: g = 40'h7F09090906;
      6'd49: g = 40'h3E4151215E;
      6'd50: g = 40'h7F09192946;
      6'd51: g = 40'h4649494931;
      6'd52: g = 40'h01017F0101;
      6'd53: g = 40'h3F4040403F;
      6'd54: g = 40'h1F2040201F;
      6'd55: g = 40'h3F4038403F;
      6'd56: g = 40'h6314081463;
      6'd57: g = 40'h0708700807;
      6'd58: g = 40'h6151494543;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* src/glyph_cell_rasterizer.sv */
// Top level of the glyph cell rasterizer: config registers, front, queue and back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  in      | input     | in_valid / in_ready    | char_code, origin_x, origin_y
//  out     | output    | out_valid / out_ready  | win_left/top/right/bottom, fill_colour,
//          |           |                        | visible, last
//  cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// Each character yields CELL_COLUMNS * CELL_ROWS beats (48 by default), one per cycle unless out stalls;
// the cell walker in the back stage sets this figure.
// From an empty pipe, a character passes the front register, a queue entry, the walker and the result register.
// Front register and a two-entry queue take following characters while the walker runs,
// and the walker moves to the next character with no gap between beats.
// Reset restores the config defaults and empties all stages; no clearing pass.
// A stall on out holds the result register and freezes the walker; in keeps filling.
module glyph_cell_rasterizer #(
  parameter int CELL_COLUMNS = 6,
  parameter int CELL_ROWS    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gcr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gcr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          char_code,
  input  logic signed [15:0]                  origin_x,
  input  logic signed [15:0]                  origin_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gcr_pkg::WIN_W-1:0]           win_left,
  output logic [gcr_pkg::WIN_W-1:0]           win_top,
  output logic [gcr_pkg::WIN_W-1:0]           win_right,
  output logic [gcr_pkg::WIN_W-1:0]           win_bottom,
  output logic [gcr_pkg::COLOUR_W-1:0]        fill_colour,
  output logic                                visible,
  output logic                                last
);

  gcr_pkg::cfg_t  cfg;
  logic           front_valid;
  logic           front_ready;
  gcr_pkg::item_t front_item;
  logic           queue_valid;
  logic           queue_ready;
  gcr_pkg::item_t queue_item;
  gcr_pkg::cell_t out_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 12'd240;
      cfg.screen_height <= 12'd240;
      cfg.cell_scale    <= 8'd1;
      cfg.fore_colour   <= 16'hFFFF;
      cfg.back_colour   <= 16'h0000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gcr_pkg::REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[gcr_pkg::WIN_W-1:0];
        gcr_pkg::REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[gcr_pkg::WIN_W-1:0];
        gcr_pkg::REG_CELL_SCALE:    cfg.cell_scale    <= cfg_data[gcr_pkg::SCALE_W-1:0];
        gcr_pkg::REG_FORE_COLOUR:   cfg.fore_colour   <= cfg_data;
        gcr_pkg::REG_BACK_COLOUR:   cfg.back_colour   <= cfg_data;
        default: ;
      endcase
    end
  end

  gcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  gcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  gcr_back #(
    .CELL_COLUMNS (CELL_COLUMNS),
    .CELL_ROWS    (CELL_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_cell   (out_beat)
  );

  assign win_left    = out_beat.win_left;
  assign win_top     = out_beat.win_top;
  assign win_right   = out_beat.win_right;
  assign win_bottom  = out_beat.win_bottom;
  assign fill_colour = out_beat.fill_colour;
  assign visible     = out_beat.visible;
  assign last        = out_beat.last;

endmodule

/* src/gcr_front.sv */
// Front stage: accepts a character beat, classifies the code and fetches its glyph.
module gcr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic signed [15:0]  origin_x,
  input  logic signed [15:0]  origin_y,
  output logic                item_valid,
  input  logic                item_ready,
  output gcr_pkg::item_t      item
);

  gcr_pkg::item_t item_next;

  assign in_ready = !item_valid || item_ready;

  always_comb begin
    item_next.glyph    = gcr_pkg::font_glyph(gcr_pkg::char_to_index(char_code));
    item_next.origin_x = origin_x;
    item_next.origin_y = origin_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

/* src/gcr_queue.sv */
// Two-entry queue of classified characters between front and back.
module gcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  gcr_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gcr_pkg::item_t pop_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  gcr_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = count != (PTR_W+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* src/gcr_back.sv */
// Back stage: walks the cell grid of one character, clips each cell, holds the result beat.
module gcr_back #(
  parameter int CELL_COLUMNS = 6,
  parameter int CELL_ROWS    = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  gcr_pkg::cfg_t  cfg,
  input  logic           item_valid,
  output logic           item_ready,
  input  gcr_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output gcr_pkg::cell_t out_cell
);

  localparam int COL_W = $clog2(CELL_COLUMNS);
  localparam int ROW_W = $clog2(CELL_ROWS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(CELL_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(CELL_ROWS - 1);

  logic                     active;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  gcr_pkg::coord_t          x;
  gcr_pkg::coord_t          xe;
  gcr_pkg::coord_t          y;
  gcr_pkg::coord_t          ye;
  gcr_pkg::coord_t          col_top;
  gcr_pkg::coord_t          col_top_end;
  gcr_pkg::glyph_t          glyph;

  gcr_pkg::coord_t          scale;
  gcr_pkg::coord_t          lim_x;
  gcr_pkg::coord_t          lim_y;
  gcr_pkg::coord_t          ax;
  gcr_pkg::coord_t          bx;
  gcr_pkg::coord_t          ay;
  gcr_pkg::coord_t          by;
  gcr_pkg::coord_t          bx_m1;
  gcr_pkg::coord_t          by_m1;
  gcr_pkg::coord_t          ox_ext;
  gcr_pkg::coord_t          oy_ext;
  logic [gcr_pkg::GLYPH_ROWS-1:0] col_byte;
  logic                     vis;
  logic                     is_last;
  logic                     adv;
  logic                     load;
  gcr_pkg::cell_t           cell_next;

  assign scale  = gcr_pkg::coord_t'(cfg.cell_scale);
  assign lim_x  = gcr_pkg::coord_t'(cfg.screen_width);
  assign lim_y  = gcr_pkg::coord_t'(cfg.screen_height);
  assign ox_ext = gcr_pkg::coord_t'(item.origin_x);
  assign oy_ext = gcr_pkg::coord_t'(item.origin_y);

  assign is_last    = (col == COL_LAST) && (row == ROW_LAST);
  assign adv        = active && (!out_valid || out_ready);
  assign load       = item_valid && (!active || (adv && is_last));
  assign item_ready = load;

  // columns past the glyph are blank
  always_comb begin
    col_byte = '0;
    for (int i = 0; i < gcr_pkg::GLYPH_COLS; i++) begin
      if (col == COL_W'(i)) begin
        col_byte = glyph[i];
      end
    end
  end

  // xe and ye already hold the far edge, so the clip is compares and one decrement per axis
  always_comb begin
    ax    = x[gcr_pkg::COORD_W-1] ? '0 : x;
    bx    = (xe > lim_x) ? lim_x : xe;
    ay    = y[gcr_pkg::COORD_W-1] ? '0 : y;
    by    = (ye > lim_y) ? lim_y : ye;
    bx_m1 = bx - gcr_pkg::coord_t'(1);
    by_m1 = by - gcr_pkg::coord_t'(1);
    vis   = (ax < bx) && (ay < by);

    cell_next.win_left    = vis ? ax[gcr_pkg::WIN_W-1:0] : '0;
    cell_next.win_top     = vis ? ay[gcr_pkg::WIN_W-1:0] : '0;
    cell_next.win_right   = vis ? bx_m1[gcr_pkg::WIN_W-1:0] : '0;
    cell_next.win_bottom  = vis ? by_m1[gcr_pkg::WIN_W-1:0] : '0;
    cell_next.fill_colour = col_byte[row] ? cfg.fore_colour : cfg.back_colour;
    cell_next.visible     = vis;
    cell_next.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      col    <= '0;
      row    <= '0;
    end else if (load) begin
      active <= 1'b1;
      col    <= '0;
      row    <= '0;
    end else if (adv) begin
      if (is_last) begin
        active <= 1'b0;
      end else if (row == ROW_LAST) begin
        row <= '0;
        col <= col + 1'b1;
      end else begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph       <= item.glyph;
      x           <= ox_ext;
      xe          <= ox_ext + scale;
      y           <= oy_ext;
      ye          <= oy_ext + scale;
      col_top     <= oy_ext;
      col_top_end <= oy_ext + scale;
    end else if (adv) begin
      if (row == ROW_LAST) begin
        x  <= xe;
        xe <= xe + scale;
        y  <= col_top;
        ye <= col_top_end;
      end else begin
        y  <= ye;
        ye <= ye + scale;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cell <= cell_next;
    end
  end

`ifndef SYNTHESIS
  a_hidden_zero_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_cell.visible |->
      out_cell.win_left == '0 && out_cell.win_top == '0 &&
      out_cell.win_right == '0 && out_cell.win_bottom == '0)
    else $error("invisible cell with nonzero window");

  a_window_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_cell.visible |->
      out_cell.win_left <= out_cell.win_right && out_cell.win_top <= out_cell.win_bottom)
    else $error("visible cell with inverted window");

  a_pop_on_boundary: assert property (@(posedge clk) disable iff (rst)
    load && active |-> adv && is_last)
    else $error("new character loaded mid-walk");

  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    adv && is_last |=> out_valid && out_cell.last)
    else $error("final cell not flagged last");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for glyph_cell_rasterizer: predicted cell rectangles vs. output beats.
`timescale 1ns / 100ps

module testbench;

  localparam int CELL_COLUMNS    = 6;
  localparam int CELL_ROWS       = 8;
  localparam int IDLE_PCT        = 21;
  localparam int CALM_FROM       = 250;   // no idling on either side in this char window
  localparam int CALM_TO         = 330;
  localparam int HOLD_AT         = 150;   // receiver backs off once this many chars are in
  localparam int HOLD_CYCLES     = 600;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_PRINTED     = 40;
  localparam int RANDOM_PHASES   = 9;
  localparam int CHARS_PER_PHASE = 36;

  localparam logic [gcr_pkg::CFG_INDEX_W-1:0] REG_FIRST_SPARE = 3'd5;
  localparam logic [gcr_pkg::CFG_INDEX_W-1:0] REG_LAST_SPARE  = 3'd7;

  // 5x7 font, one entry per code from space to 'Z'; leftmost column in the top byte
  localparam logic [39:0] GLYPHS [59] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  typedef struct packed {
    logic [7:0]         code;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } char_beat_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [gcr_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [gcr_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [7:0]                         char_code = '0;
  logic signed [15:0]                 origin_x = '0;
  logic signed [15:0]                 origin_y = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [gcr_pkg::WIN_W-1:0]          win_left;
  logic [gcr_pkg::WIN_W-1:0]          win_top;
  logic [gcr_pkg::WIN_W-1:0]          win_right;
  logic [gcr_pkg::WIN_W-1:0]          win_bottom;
  logic [gcr_pkg::COLOUR_W-1:0]       fill_colour;
  logic                               visible;
  logic                               last;

  char_beat_t     pending_chars[$];
  gcr_pkg::cell_t cells_due[$];
  char_beat_t     offered;
  gcr_pkg::cfg_t  shadow;
  gcr_pkg::cell_t want;
  int             chars_taken = 0;
  int             cells_checked = 0;
  int             cells_on = 0;
  int             settings_used = 0;
  int             errors = 0;
  int             quiet_cycles = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  logic           calm;

  glyph_cell_rasterizer #(
    .CELL_COLUMNS(CELL_COLUMNS),
    .CELL_ROWS   (CELL_ROWS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .win_left   (win_left),
    .win_top    (win_top),
    .win_right  (win_right),
    .win_bottom (win_bottom),
    .fill_colour(fill_colour),
    .visible    (visible),
    .last       (last)
  );

  always #1 clk = ~clk;

  assign calm = chars_taken >= CALM_FROM && chars_taken < CALM_TO;

  task automatic flag(string msg);
    if (errors < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      flag($sformatf("cell %0d (char %0d) %s got 0x%0h want 0x%0h", cells_checked,
                     cells_checked / (CELL_COLUMNS * CELL_ROWS), name, got, exp_val));
  endtask

  // span [start, start+len) clipped to [0, limit)
  function automatic bit clip_span(int start, int len, int limit, output int lo, output int hi);
    int a;
    int b;
    a = (start < 0) ? 0 : start;
    b = (start + len > limit) ? limit : start + len;
    lo = a;
    hi = b - 1;
    return len > 0 && a < b;
  endfunction

  // expands one accepted character into its cell rectangles
  function automatic void raster_char(char_beat_t ch);
    logic [7:0]     c;
    logic [39:0]    glyph;
    logic [7:0]     bits;
    int             s, l, r, t, b;
    bit             vx, vy;
    gcr_pkg::cell_t beat;
    c = ch.code;
    if (c >= gcr_pkg::CHAR_LOWER_A && c <= gcr_pkg::CHAR_LOWER_Z) c = c - gcr_pkg::CASE_OFFSET;
    if (c < gcr_pkg::CHAR_SPACE || c > gcr_pkg::CHAR_UPPER_Z) c = gcr_pkg::CHAR_QMARK;
    glyph = GLYPHS[c - gcr_pkg::CHAR_SPACE];
    s = int'(shadow.cell_scale);
    for (int col = 0; col < CELL_COLUMNS; col++) begin
      bits = (col < gcr_pkg::GLYPH_COLS) ? glyph[39 - 8 * col -: 8] : 8'h00;
      for (int row = 0; row < CELL_ROWS; row++) begin
        vx = clip_span(int'(ch.x) + col * s, s, int'(shadow.screen_width), l, r);
        vy = clip_span(int'(ch.y) + row * s, s, int'(shadow.screen_height), t, b);
        beat.visible     = vx && vy;
        beat.win_left    = beat.visible ? l[gcr_pkg::WIN_W-1:0] : '0;
        beat.win_right   = beat.visible ? r[gcr_pkg::WIN_W-1:0] : '0;
        beat.win_top     = beat.visible ? t[gcr_pkg::WIN_W-1:0] : '0;
        beat.win_bottom  = beat.visible ? b[gcr_pkg::WIN_W-1:0] : '0;
        beat.fill_colour = bits[row] ? shadow.fore_colour : shadow.back_colour;
        beat.last        = (col == CELL_COLUMNS - 1) && (row == CELL_ROWS - 1);
        cells_due.push_back(beat);
      end
    end
  endfunction

  task automatic write_reg(logic [gcr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [gcr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      gcr_pkg::REG_SCREEN_WIDTH:  shadow.screen_width  = val[gcr_pkg::WIN_W-1:0];
      gcr_pkg::REG_SCREEN_HEIGHT: shadow.screen_height = val[gcr_pkg::WIN_W-1:0];
      gcr_pkg::REG_CELL_SCALE:    shadow.cell_scale    = val[gcr_pkg::SCALE_W-1:0];
      gcr_pkg::REG_FORE_COLOUR:   shadow.fore_colour   = val;
      gcr_pkg::REG_BACK_COLOUR:   shadow.back_colour   = val;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (pending_chars.size() != 0 || in_valid || cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_used++;
  endtask

  function automatic void queue_char(logic [7:0] code, int x, int y);
    char_beat_t ch;
    ch.code = code;
    ch.x    = 16'(x);
    ch.y    = 16'(y);
    pending_chars.push_back(ch);
  endfunction

  // position that puts the character on, across or just off an edge
  function automatic logic signed [15:0] near_origin(int extent, int limit);
    return 16'(-extent - 4 + int'($urandom_range(limit + extent + 8)));
  endfunction

  function automatic void queue_random_char();
    char_beat_t ch;
    int         s;
    s = int'(shadow.cell_scale);
    case ($urandom_range(2))
      0: ch.code = 8'($urandom);
      1: ch.code = 8'($urandom_range(gcr_pkg::CHAR_UPPER_Z, gcr_pkg::CHAR_SPACE));
      default: ch.code = 8'($urandom_range(gcr_pkg::CHAR_LOWER_Z, gcr_pkg::CHAR_LOWER_A));
    endcase
    ch.x = ($urandom_range(9) < 7) ? near_origin(CELL_COLUMNS * s, int'(shadow.screen_width))
                                   : 16'($urandom);
    ch.y = ($urandom_range(9) < 7) ? near_origin(CELL_ROWS * s, int'(shadow.screen_height))
                                   : 16'($urandom);
    pending_chars.push_back(ch);
  endfunction

  function automatic logic [15:0] pick_extent();
    case ($urandom_range(3))
      0: return 16'($urandom_range(64, 1));
      1: return 16'($urandom_range(400, 1));
      2: return 16'($urandom_range(4095, 1));
      default: return {4'($urandom_range(15, 1)), 12'($urandom_range(300, 1))};
    endcase
  endfunction

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        raster_char(offered);
        chars_taken <= chars_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          offered = pending_chars.pop_front();
          in_valid  <= 1'b1;
          char_code <= offered.code;
          origin_x  <= offered.x;
          origin_y  <= offered.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side backpressure, with one long back-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!hold_done && chars_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        flag($sformatf("cell beat %0d arrived with nothing expected", cells_checked));
      end else begin
        want = cells_due.pop_front();
        check_field("win_left", 16'(win_left), 16'(want.win_left));
        check_field("win_top", 16'(win_top), 16'(want.win_top));
        check_field("win_right", 16'(win_right), 16'(want.win_right));
        check_field("win_bottom", 16'(win_bottom), 16'(want.win_bottom));
        check_field("fill_colour", fill_colour, want.fill_colour);
        check_field("visible", 16'(visible), 16'(want.visible));
        check_field("last", 16'(last), 16'(want.last));
        if (want.visible) cells_on++;
      end
      cells_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d chars queued, %0d cells outstanding",
               quiet_cycles, pending_chars.size(), cells_due.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    shadow.screen_width  = 12'd240;
    shadow.screen_height = 12'd240;
    shadow.cell_scale    = 8'd1;
    shadow.fore_colour   = 16'hFFFF;
    shadow.back_colour   = 16'h0000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: code mapping edges and position extremes
    queue_char(8'd0, 0, 0);
    queue_char(gcr_pkg::CHAR_SPACE - 8'd1, 10, 10);
    queue_char(gcr_pkg::CHAR_SPACE, 0, 0);
    queue_char(gcr_pkg::CHAR_UPPER_Z, 234, 232);
    queue_char(gcr_pkg::CHAR_UPPER_Z + 8'd1, 235, 233);
    queue_char(gcr_pkg::CHAR_LOWER_A, -3, -5);
    queue_char(gcr_pkg::CHAR_LOWER_Z, 100, 100);
    queue_char(gcr_pkg::CHAR_LOWER_A - 8'd1, 50, 20);
    queue_char(gcr_pkg::CHAR_LOWER_Z + 8'd1, 20, 50);
    queue_char(8'd127, 60, 60);
    queue_char(8'd128, 70, 70);
    queue_char(8'd255, 80, 80);
    queue_char(8'd65, 1, 1);
    queue_char(8'd48, 120, 7);
    queue_char(8'd87, -32768, -32768);
    queue_char(8'd77, 32767, 32767);
    queue_char(8'd72, -32768, 0);
    queue_char(8'd56, 0, 32767);
    queue_char(8'd33, 239, 239);
    queue_char(8'd77, -5, 0);
    queue_char(8'd87, 240, 0);
    queue_char(8'd35, -6, -8);
    wait_drain();

    // largest screen and scale
    write_reg(gcr_pkg::REG_SCREEN_WIDTH, 16'd4095);
    write_reg(gcr_pkg::REG_SCREEN_HEIGHT, 16'd4095);
    write_reg(gcr_pkg::REG_CELL_SCALE, 16'd255);
    write_reg(gcr_pkg::REG_FORE_COLOUR, 16'($urandom));
    write_reg(gcr_pkg::REG_BACK_COLOUR, 16'($urandom));
    queue_char(gcr_pkg::CHAR_UPPER_Z, 4095 - 255 * CELL_COLUMNS, 4095 - 255 * CELL_ROWS);
    queue_char(8'd66, 0, 0);
    repeat (38) queue_random_char();
    wait_drain();

    // too-wide writes: scale truncates to zero, width keeps its low bits
    write_reg(gcr_pkg::REG_CELL_SCALE, 16'h0100);
    write_reg(gcr_pkg::REG_SCREEN_WIDTH, 16'hF0F0);
    repeat (20) queue_random_char();
    wait_drain();

    // zero-size screen, one axis at a time
    write_reg(gcr_pkg::REG_CELL_SCALE, 16'd3);
    write_reg(gcr_pkg::REG_SCREEN_WIDTH, 16'h1000);
    write_reg(gcr_pkg::REG_SCREEN_HEIGHT, 16'd50);
    repeat (15) queue_random_char();
    wait_drain();
    write_reg(gcr_pkg::REG_SCREEN_WIDTH, 16'd200);
    write_reg(gcr_pkg::REG_SCREEN_HEIGHT, 16'd0);
    repeat (15) queue_random_char();
    wait_drain();

    // one-pixel screen, colour extremes, writes to unused indexes must not land
    write_reg(gcr_pkg::REG_SCREEN_WIDTH, 16'd1);
    write_reg(gcr_pkg::REG_SCREEN_HEIGHT, 16'd1);
    write_reg(gcr_pkg::REG_CELL_SCALE, 16'd1);
    write_reg(gcr_pkg::REG_FORE_COLOUR, 16'h0000);
    write_reg(gcr_pkg::REG_BACK_COLOUR, 16'hFFFF);
    write_reg(REG_FIRST_SPARE, 16'h0000);
    write_reg(REG_LAST_SPARE, 16'hFFFF);
    write_reg(REG_FIRST_SPARE + 3'd1, 16'h5A5A);
    queue_char(8'd35, 0, 0);
    queue_char(gcr_pkg::CHAR_SPACE, 0, 0);
    repeat (18) queue_random_char();
    wait_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(gcr_pkg::REG_SCREEN_WIDTH, pick_extent());
      write_reg(gcr_pkg::REG_SCREEN_HEIGHT, pick_extent());
      write_reg(gcr_pkg::REG_CELL_SCALE, ($urandom_range(3) == 0) ? 16'($urandom_range(255, 1))
                                                                : 16'($urandom_range(12, 1)));
      write_reg(gcr_pkg::REG_FORE_COLOUR, 16'($urandom));
      write_reg(gcr_pkg::REG_BACK_COLOUR, 16'($urandom));
      if (p % 3 == 0)
        write_reg(gcr_pkg::CFG_INDEX_W'($urandom_range(REG_LAST_SPARE, REG_FIRST_SPARE)),
                  16'($urandom));
      repeat (CHARS_PER_PHASE) queue_random_char();
      wait_drain();
    end

    $display("Covered %0d characters as %0d cells (%0d on screen) across %0d register settings,",
             chars_taken, cells_checked, cells_on, settings_used);
    $display("including zero scale, empty and one-pixel screens and a long output back-off.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gcr_pkg.sv
src/gcr_front.sv
src/gcr_queue.sv
src/gcr_back.sv
src/glyph_cell_rasterizer.sv
test/testbench.sv
